[hw/rtl/lisa_pkg.sv]
package lisa_pkg;

	localparam int unsigned SLOT_W  = 10;
	localparam int unsigned COUNT_W = 11;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SLOT  = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  granted_slot;
		status_t            status;
		logic [COUNT_W-1:0] free_slots;
	} rsp_t;

endpackage

[hw/rtl/lisa_link_ram.sv]
module lisa_link_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10,
	parameter int unsigned DW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/lazy_init_slot_allocator.sv]
// Fixed-size slot allocator with a lazily initialized free list.
//
// Request channel: start/busy with payload req (op, slot_index). A request is
// taken at a rising edge with start high and busy low. An allocate returns the
// next never-used slot while every initialized slot is in use, otherwise it pops
// the free list head; a free pushes the slot onto the list head.
// Result channel: done is high for exactly one cycle with rsp (granted_slot,
// status, free_slots). The receiver cannot stall; each request gives one result.
// The result is registered in the EXEC state, which follows the accepting edge,
// and done rises with it. busy is high in EXEC, so a new request is taken only
// after the current one: the link memory read at the list head is registered
// before the new head is known, and busy covers that state.
// Config channel: cfg_valid/cfg_ready with cfg_data sets the slot limit. It is
// always ready; write it only while no request is pending (the block does not enforce this).
// Reset: counters and list head clear, the limit returns to 1024. The link
// memory is not cleared; an entry is only used after a free has written it.
module lazy_init_slot_allocator #(
	parameter int unsigned POOL_SLOTS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  lisa_pkg::req_t                      req,
	output logic                                done,
	output lisa_pkg::rsp_t                      rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lisa_pkg::COUNT_W-1:0]        cfg_data
);

	localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);
	localparam int unsigned IDX_W = $clog2(POOL_SLOTS);
	localparam int unsigned CW    = (CNT_W > lisa_pkg::COUNT_W) ? CNT_W : lisa_pkg::COUNT_W;
	localparam logic [CW-1:0] POOL_C = CW'(POOL_SLOTS);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                       state_q;
	lisa_pkg::req_t               req_q;
	logic [CNT_W-1:0]             head_q;
	logic [CNT_W-1:0]             init_q;
	logic [CNT_W-1:0]             used_q;
	logic [lisa_pkg::COUNT_W-1:0] limit_q;
	logic                         done_q;
	lisa_pkg::rsp_t               rsp_q;

	logic             accept;
	logic [CNT_W-1:0] link_rdata;
	logic             link_we;

	logic [CW-1:0]    limit_eff;
	logic [CW-1:0]    head_w;
	logic [CW-1:0]    init_w;
	logic [CW-1:0]    used_w;
	logic [CW-1:0]    slot_w;
	logic [CNT_W-1:0] head_nxt;
	logic [CNT_W-1:0] init_nxt;
	logic [CNT_W-1:0] used_nxt;
	logic [CW-1:0]    granted_w;
	lisa_pkg::status_t status_nxt;
	logic [CW-1:0]    used_nxt_w;
	logic [CW-1:0]    free_w;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	lisa_link_ram #(
		.DEPTH (POOL_SLOTS),
		.AW    (IDX_W),
		.DW    (CNT_W)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (slot_w[IDX_W-1:0]),
		.wdata (head_q),
		.re    (accept),
		.raddr (head_q[IDX_W-1:0]),
		.rdata (link_rdata)
	);

	always_comb begin
		limit_eff  = (CW'(limit_q) > POOL_C) ? POOL_C : CW'(limit_q);
		head_w     = CW'(head_q);
		init_w     = CW'(init_q);
		used_w     = CW'(used_q);
		slot_w     = CW'(req_q.slot_index);
		head_nxt   = head_q;
		init_nxt   = init_q;
		used_nxt   = used_q;
		granted_w  = '0;
		status_nxt = lisa_pkg::ST_OK;
		link_we    = 1'b0;
		if (req_q.op == lisa_pkg::OP_ALLOC) begin
			if (used_w >= limit_eff) begin
				status_nxt = lisa_pkg::ST_NO_SLOT;
			end else if (init_q == used_q) begin
				granted_w = init_w;
				init_nxt  = init_q + CNT_W'(1);
				head_nxt  = init_q + CNT_W'(1);
				used_nxt  = used_q + CNT_W'(1);
			end else begin
				granted_w = head_w;
				head_nxt  = (head_w < POOL_C) ? link_rdata : '0;
				used_nxt  = used_q + CNT_W'(1);
			end
		end else begin
			if (slot_w >= init_w || used_q == '0 || slot_w >= POOL_C) begin
				status_nxt = lisa_pkg::ST_BAD_FREE;
			end else begin
				link_we  = (state_q == S_EXEC);
				head_nxt = slot_w[CNT_W-1:0];
				used_nxt = used_q - CNT_W'(1);
			end
		end
		used_nxt_w = CW'(used_nxt);
		free_w     = (used_nxt_w >= limit_eff) ? '0 : (limit_eff - used_nxt_w);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			init_q  <= '0;
			used_q  <= '0;
			limit_q <= lisa_pkg::COUNT_W'(1024);
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					head_q             <= head_nxt;
					init_q             <= init_nxt;
					used_q             <= used_nxt;
					rsp_q.granted_slot <= granted_w[lisa_pkg::SLOT_W-1:0];
					rsp_q.status       <= status_nxt;
					rsp_q.free_slots   <= free_w[lisa_pkg::COUNT_W-1:0];
					done_q             <= 1'b1;
					state_q            <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a request is in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("request did not finish after the link read");

	a_used_le_init: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= init_q)
		else $error("used count exceeds initialized count");

	a_init_le_pool: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(init_q) <= POOL_C)
		else $error("initialized count beyond pool size");

endmodule
